// ----- sv/pca_projection_engine_defines.svh -----
// Assertion macros for the PCA projection engine.
// Included by modules that carry concurrent checks; depends on nothing else.
`ifndef PCA_PROJECTION_ENGINE_DEFINES_SVH
`define PCA_PROJECTION_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define PPE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pca projection engine check failed");
`define PPE_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("pca projection engine check failed");
`else
`define PPE_ASSERT(lbl, clk, rst, prop)
`define PPE_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- sv/ppe_pkg.sv -----
// Shared types, codes and rounding helpers of the PCA projection engine.
// Depends on nothing; used by the top level.
package ppe_pkg;

   localparam int CountWidth = 7;

   typedef enum logic [2:0] {
      CMD_LOAD_MEAN  = 3'd0,
      CMD_LOAD_BASIS = 3'd1,
      CMD_LOAD_FGAIN = 3'd2,
      CMD_LOAD_IGAIN = 3'd3,
      CMD_DATA       = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      REG_INVERSE_MODE  = 2'd0,
      REG_WHITEN_ENABLE = 2'd1,
      REG_FEATURES      = 2'd2,
      REG_COMPONENTS    = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FMEAN,
      ST_FDIFF,
      ST_FMAC,
      ST_FDRAIN,
      ST_FEMIT,
      ST_IRUN
   } state_type;

   typedef struct packed {
      logic [2:0]          cmd;
      logic [3:0]          row_index;
      logic [5:0]          col_index;
      logic signed [15:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [31:0]  result_value;
      logic [5:0]          result_index;
      logic                last;
   } rsp_type;

   // Round to nearest, ties toward plus infinity, by 2^27 or 2^15.
   function automatic logic signed [63:0] round_q(input logic signed [63:0] v,
                                                  input logic wide);
      logic signed [63:0] t;
      begin
         if (wide) begin
            t = v + 64'sd67108864;
            round_q = t >>> 27;
         end else begin
            t = v + 64'sd16384;
            round_q = t >>> 15;
         end
      end
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      begin
         if (v > 64'sd2147483647) begin
            sat32 = 32'sh7fffffff;
         end else if (v < -64'sd2147483648) begin
            sat32 = 32'sh80000000;
         end else begin
            sat32 = v[31:0];
         end
      end
   endfunction

endpackage

// ----- sv/ppe_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; instanced for every table of the PCA projection engine.
module ppe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [2**AW];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- sv/pca_projection_engine.sv -----
// Top level of the PCA projection engine: command decode, sequencer and datapath.
// Depends on ppe_pkg, ppe_ram and pca_projection_engine_defines.svh.
//
// Usage. Items enter on req_data when start is high and busy is low. Load
// commands write the mean, basis or gain tables in that same cycle and leave
// busy low. A data element in forward mode reads its mean, then runs one
// multiply-accumulate per component through the accumulator RAM, one
// component a cycle; busy stays high until the element is done. After the
// last feature the scores stream out, one per cycle, through the e1 and e2
// stages and the output register. In inverse mode each score is written to
// the score buffer; the last one starts a reconstruction that reads one basis
// word per cycle, each feature's sum passing the i1, i2 and i3 stages. The
// rate is set by the single read port of the basis RAM.
// Results appear on rsp_data for one cycle each, marked by rsp_valid; the
// receiver cannot stall them. Configuration writes go through csr_valid and
// csr_ready, are taken only while busy is low and drop any partial sample.
// Reset is synchronous: registers return to their defaults, the sample is
// dropped, and table contents stay undefined until loaded. No clearing pass.
module pca_projection_engine
   import ppe_pkg::*;
#(
   parameter int MAX_FEATURES   = 64,
   parameter int MAX_COMPONENTS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  req_type      req_data,
   output logic         busy,
   output logic         rsp_valid,
   output rsp_type      rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [6:0]   csr_wdata
);
   `include "pca_projection_engine_defines.svh"

   localparam int FW  = $clog2(MAX_FEATURES);
   localparam int KW  = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
   localparam int BD  = MAX_COMPONENTS * MAX_FEATURES;
   localparam int BAW = $clog2(BD);

   // Configuration registers.
   logic                  inverse_ff, whiten_ff;
   logic [6:0]            feat_ff;
   logic [4:0]            comp_ff;
   logic [6:0]            nf, nc;

   // Sequencer.
   state_type             state_ff, state_in;
   logic [CountWidth-1:0] cnt_ff, cnt_in;
   logic [KW-1:0]         k_ff, k_in;
   logic [FW-1:0]         j_ff, j_in;
   logic signed [15:0]    val_ff;
   logic signed [16:0]    diff_ff, diff_in;

   // Pipeline stages.
   logic                  p1_valid_ff, p1_valid_in;
   logic [KW-1:0]         p1_k_ff;
   logic                  e1_valid_ff, e1_valid_in, e1_last_ff;
   logic [KW-1:0]         e1_k_ff;
   logic                  e2_valid_ff, e2_last_ff;
   logic [KW-1:0]         e2_k_ff;
   logic signed [63:0]    prod_ff;
   logic                  i1_valid_ff, i1_valid_in, i1_kfirst_ff, i1_klast_ff, i1_jlast_ff;
   logic [FW-1:0]         i1_j_ff;
   logic                  i2_valid_ff, i2_kfirst_ff, i2_klast_ff, i2_jlast_ff;
   logic [FW-1:0]         i2_j_ff;
   logic signed [31:0]    z_ff;
   logic signed [15:0]    bd_ff, m2_ff, m3_ff;
   logic signed [51:0]    sum_ff;
   logic                  i3_valid_ff, i3_jlast_ff;
   logic [FW-1:0]         i3_j_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff, rsp_in;

   // Memory ports.
   logic                  mean_we, basis_we, fg_we, ig_we, acc_we, sb_we;
   logic [FW-1:0]         mean_raddr, mean_waddr;
   logic [BAW-1:0]        basis_raddr, basis_waddr;
   logic [KW-1:0]         gain_raddr, gain_waddr, acc_raddr, sb_waddr;
   logic [15:0]           mean_rdata, basis_rdata, fg_rdata, ig_rdata, sb_rdata;
   logic [39:0]           acc_rdata, acc_wdata;

   logic                  accept, is_data, cfg_write, row_ok, col_ok;
   logic [FW-1:0]         f_idx;
   logic [KW-1:0]         c_idx;
   logic [CountWidth-1:0] cnt_next;
   logic signed [39:0]    acc_base;

   assign nf = (feat_ff == 7'd0) ? 7'd1 :
               ((int'(feat_ff) > MAX_FEATURES) ? 7'(MAX_FEATURES) : feat_ff);
   assign nc = (comp_ff == 5'd0) ? 7'd1 :
               ((int'(comp_ff) > MAX_COMPONENTS) ? 7'(MAX_COMPONENTS) : {2'b00, comp_ff});

   assign accept    = start && !busy;
   assign is_data   = req_data.cmd == CMD_DATA;
   assign csr_ready = !busy;
   assign cfg_write = csr_valid && csr_ready;
   assign row_ok    = int'(req_data.row_index) < MAX_COMPONENTS;
   assign col_ok    = int'(req_data.col_index) < MAX_FEATURES;
   assign cnt_next  = cnt_ff + 1'b1;
   assign f_idx     = (int'(cnt_ff) >= MAX_FEATURES) ? FW'(MAX_FEATURES - 1) : cnt_ff[FW-1:0];
   assign c_idx     = (int'(cnt_ff) >= MAX_COMPONENTS) ? KW'(MAX_COMPONENTS - 1) : KW'(cnt_ff);

   assign busy = (state_ff != ST_IDLE) || p1_valid_ff || e1_valid_ff || e2_valid_ff ||
                 i1_valid_ff || i2_valid_ff || i3_valid_ff;

   // Load writes.
   assign mean_we     = accept && req_data.cmd == CMD_LOAD_MEAN && col_ok;
   assign mean_waddr  = req_data.col_index[FW-1:0];
   assign basis_we    = accept && req_data.cmd == CMD_LOAD_BASIS && row_ok && col_ok;
   assign basis_waddr = BAW'(int'(req_data.row_index) * MAX_FEATURES +
                             int'(req_data.col_index));
   assign fg_we       = accept && req_data.cmd == CMD_LOAD_FGAIN && row_ok;
   assign ig_we       = accept && req_data.cmd == CMD_LOAD_IGAIN && row_ok;
   assign gain_waddr  = KW'(req_data.row_index);
   assign sb_we       = accept && is_data && inverse_ff;
   assign sb_waddr    = c_idx;

   // Forward multiply-accumulate; the first feature overwrites the stale entry.
   assign acc_we    = p1_valid_ff;
   assign acc_base  = (cnt_ff == '0) ? 40'sd0 : $signed(acc_rdata);
   assign acc_wdata = acc_base + diff_ff * $signed(basis_rdata);

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      k_in        = k_ff;
      j_in        = j_ff;
      diff_in     = diff_ff;
      p1_valid_in = 1'b0;
      e1_valid_in = 1'b0;
      i1_valid_in = 1'b0;
      mean_raddr  = f_idx;
      basis_raddr = BAW'(int'(k_ff) * MAX_FEATURES + int'(f_idx));
      acc_raddr   = k_ff;
      gain_raddr  = k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && is_data) begin
               if (!inverse_ff) begin
                  state_in = ST_FMEAN;
               end else if (7'(cnt_next) >= nc) begin
                  cnt_in   = '0;
                  k_in     = '0;
                  j_in     = '0;
                  state_in = ST_IRUN;
               end else begin
                  cnt_in = cnt_next;
               end
            end
         end
         ST_FMEAN: begin
            k_in     = '0;
            state_in = ST_FDIFF;
         end
         ST_FDIFF, ST_FMAC: begin
            if (state_ff == ST_FDIFF) begin
               diff_in = 17'(val_ff) - 17'($signed(mean_rdata));
            end
            p1_valid_in = 1'b1;
            if (7'(k_ff) == nc - 7'd1) begin
               state_in = ST_FDRAIN;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_FMAC;
            end
         end
         ST_FDRAIN: begin
            k_in = '0;
            if (7'(cnt_next) >= nf) begin
               cnt_in   = '0;
               state_in = ST_FEMIT;
            end else begin
               cnt_in   = cnt_next;
               state_in = ST_IDLE;
            end
         end
         ST_FEMIT: begin
            e1_valid_in = 1'b1;
            if (7'(k_ff) == nc - 7'd1) begin
               state_in = ST_IDLE;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_IRUN: begin
            mean_raddr  = j_ff;
            basis_raddr = BAW'(int'(k_ff) * MAX_FEATURES + int'(j_ff));
            i1_valid_in = 1'b1;
            if (7'(k_ff) == nc - 7'd1) begin
               k_in = '0;
               if (7'(j_ff) == nf - 7'd1) begin
                  state_in = ST_IDLE;
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (cfg_write) begin
         cnt_in = '0;
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (e2_valid_ff) begin
         rsp_in.result_value = sat32(round_q(prod_ff, whiten_ff));
         rsp_in.result_index = 6'(e2_k_ff);
         rsp_in.last         = e2_last_ff;
      end else if (i3_valid_ff) begin
         rsp_in.result_value = sat32(64'(m3_ff) + round_q(64'(sum_ff), whiten_ff));
         rsp_in.result_index = 6'(i3_j_ff);
         rsp_in.last         = i3_jlast_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         inverse_ff   <= 1'b0;
         whiten_ff    <= 1'b0;
         feat_ff      <= 7'd64;
         comp_ff      <= 5'd16;
         p1_valid_ff  <= 1'b0;
         e1_valid_ff  <= 1'b0;
         e2_valid_ff  <= 1'b0;
         i1_valid_ff  <= 1'b0;
         i2_valid_ff  <= 1'b0;
         i3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         p1_valid_ff  <= p1_valid_in;
         e1_valid_ff  <= e1_valid_in;
         e2_valid_ff  <= e1_valid_ff;
         i1_valid_ff  <= i1_valid_in;
         i2_valid_ff  <= i1_valid_ff;
         i3_valid_ff  <= i2_valid_ff && i2_klast_ff;
         rsp_valid_ff <= e2_valid_ff || i3_valid_ff;
         if (cfg_write) begin
            unique case (csr_index)
               REG_INVERSE_MODE:  inverse_ff <= csr_wdata[0];
               REG_WHITEN_ENABLE: whiten_ff  <= csr_wdata[0];
               REG_FEATURES:      feat_ff    <= csr_wdata;
               REG_COMPONENTS:    comp_ff    <= csr_wdata[4:0];
               default:           ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      j_ff    <= j_in;
      diff_ff <= diff_in;
      rsp_ff  <= rsp_in;
      if (accept) begin
         val_ff <= req_data.value;
      end
      p1_k_ff    <= k_ff;
      e1_k_ff    <= k_ff;
      e1_last_ff <= 7'(k_ff) == nc - 7'd1;
      e2_k_ff    <= e1_k_ff;
      e2_last_ff <= e1_last_ff;
      if (whiten_ff) begin
         prod_ff <= 64'($signed(acc_rdata) * $signed({1'b0, fg_rdata}));
      end else begin
         prod_ff <= 64'($signed(acc_rdata));
      end
      i1_kfirst_ff <= k_ff == '0;
      i1_klast_ff  <= 7'(k_ff) == nc - 7'd1;
      i1_jlast_ff  <= 7'(j_ff) == nf - 7'd1;
      i1_j_ff      <= j_ff;
      if (whiten_ff) begin
         z_ff <= 32'($signed(sb_rdata) * $signed({1'b0, ig_rdata}));
      end else begin
         z_ff <= 32'($signed(sb_rdata));
      end
      bd_ff        <= basis_rdata;
      m2_ff        <= mean_rdata;
      i2_kfirst_ff <= i1_kfirst_ff;
      i2_klast_ff  <= i1_klast_ff;
      i2_jlast_ff  <= i1_jlast_ff;
      i2_j_ff      <= i1_j_ff;
      if (i2_valid_ff) begin
         sum_ff <= (i2_kfirst_ff ? 52'sd0 : sum_ff) + 52'(z_ff * bd_ff);
      end
      m3_ff       <= m2_ff;
      i3_jlast_ff <= i2_jlast_ff;
      i3_j_ff     <= i2_j_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   ppe_ram #(.WIDTH(16), .DEPTH(MAX_FEATURES)) u_mean (
      .clock(clock), .we(mean_we), .waddr(mean_waddr), .wdata(req_data.value),
      .raddr(mean_raddr), .rdata(mean_rdata));

   ppe_ram #(.WIDTH(16), .DEPTH(BD)) u_basis (
      .clock(clock), .we(basis_we), .waddr(basis_waddr), .wdata(req_data.value),
      .raddr(basis_raddr), .rdata(basis_rdata));

   ppe_ram #(.WIDTH(16), .DEPTH(MAX_COMPONENTS)) u_fgain (
      .clock(clock), .we(fg_we), .waddr(gain_waddr), .wdata(req_data.value),
      .raddr(gain_raddr), .rdata(fg_rdata));

   ppe_ram #(.WIDTH(16), .DEPTH(MAX_COMPONENTS)) u_igain (
      .clock(clock), .we(ig_we), .waddr(gain_waddr), .wdata(req_data.value),
      .raddr(gain_raddr), .rdata(ig_rdata));

   ppe_ram #(.WIDTH(40), .DEPTH(MAX_COMPONENTS)) u_acc (
      .clock(clock), .we(acc_we), .waddr(p1_k_ff), .wdata(acc_wdata),
      .raddr(acc_raddr), .rdata(acc_rdata));

   ppe_ram #(.WIDTH(16), .DEPTH(MAX_COMPONENTS)) u_sbuf (
      .clock(clock), .we(sb_we), .waddr(sb_waddr), .wdata(req_data.value),
      .raddr(gain_raddr), .rdata(sb_rdata));

   // Scores are read only once every accumulator write has landed.
   `PPE_ASSERT(a_no_mac_during_emit, clock, reset, (state_ff == ST_FEMIT) |-> !p1_valid_ff)
   // The final result of a sample is never followed directly by another.
   `PPE_ASSERT(a_last_then_gap, clock, reset, (rsp_valid_ff && rsp_ff.last) |=> !rsp_valid_ff)
   // A partial sample at rest never holds a complete count.
   `PPE_ASSERT(a_count_bound, clock, reset,
      (state_ff == ST_IDLE) |-> (inverse_ff ? (7'(cnt_ff) < nc) : (7'(cnt_ff) < nf)))
   // Only one result source feeds the output register in a cycle.
   `PPE_ASSERT(a_one_source, clock, reset, !(e2_valid_ff && i3_valid_ff))
endmodule

// ----- sim/pca_projection_engine_test.sv -----
// Self-checking testbench of the PCA projection engine: loads tables, runs
// forward and inverse samples under several register settings, checks each result.
// Depends on ppe_pkg and the pca_projection_engine top level.
module pca_projection_engine_test;
   import ppe_pkg::*;

   localparam int NumFeat = 64;
   localparam int NumComp = 16;
   localparam int QuietLimit = 6000;
   localparam int DrainPause = 60;

   logic clock = 1'b0;
   logic reset;
   logic start;
   req_type req_data;
   logic busy;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [1:0] csr_index;
   logic [6:0] csr_wdata;

   pca_projection_engine dut (
      .clock(clock), .reset(reset),
      .start(start), .req_data(req_data), .busy(busy),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow copy of the tables, the sample in progress and the registers.
   longint mean_shadow[NumFeat];
   longint basis_shadow[NumComp*NumFeat];
   longint fgain_shadow[NumComp];
   longint igain_shadow[NumComp];
   bit mean_loaded[NumFeat];
   bit basis_loaded[NumComp*NumFeat];
   bit fgain_loaded[NumComp];
   bit igain_loaded[NumComp];
   longint score_acc[NumComp];
   longint score_held[NumComp];
   int elem_count;
   bit mode_inverse;
   bit mode_whiten;
   int feat_reg;
   int comp_reg;

   rsp_type pending_scores[$];
   int errors = 0;
   int beats_sent = 0;
   int scores_seen = 0;
   int samples_done = 0;
   int settings_used = 0;
   int quiet_cycles = 0;
   bit steady = 1'b0;

   function automatic int feat_count();
      if (feat_reg < 1) return 1;
      if (feat_reg > NumFeat) return NumFeat;
      return feat_reg;
   endfunction

   function automatic int comp_count();
      if (comp_reg < 1) return 1;
      if (comp_reg > NumComp) return NumComp;
      return comp_reg;
   endfunction

   function automatic longint round_down(longint v, int s);
      longint t;
      t = v + (longint'(1) <<< (s - 1));
      return t >>> s;
   endfunction

   function automatic logic signed [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic void clear_sample();
      for (int k = 0; k < NumComp; k++) begin
         score_acc[k] = 0;
         score_held[k] = 0;
      end
      elem_count = 0;
   endfunction

   function automatic void predict_scores(req_type r);
      longint val, diff, sum, s;
      int f, nf, nc;
      rsp_type e;
      val = longint'(r.value);
      nf = feat_count();
      nc = comp_count();
      if (!mode_inverse) begin
         f = (elem_count >= NumFeat) ? NumFeat - 1 : elem_count;
         diff = val - mean_shadow[f];
         for (int k = 0; k < nc; k++) score_acc[k] += diff * basis_shadow[k*NumFeat + f];
         elem_count++;
         if (elem_count < nf) return;
         for (int k = 0; k < nc; k++) begin
            s = mode_whiten ? round_down(score_acc[k] * fgain_shadow[k], 27)
                            : round_down(score_acc[k], 15);
            e.result_value = clip32(s);
            e.result_index = 6'(k);
            e.last = (k == nc - 1);
            pending_scores.push_back(e);
         end
      end else begin
         f = (elem_count >= NumComp) ? NumComp - 1 : elem_count;
         score_held[f] = val;
         elem_count++;
         if (elem_count < nc) return;
         for (int j = 0; j < nf; j++) begin
            sum = 0;
            for (int k = 0; k < nc; k++)
               sum += (mode_whiten ? score_held[k] * igain_shadow[k] : score_held[k])
                      * basis_shadow[k*NumFeat + j];
            s = mean_shadow[j] + round_down(sum, mode_whiten ? 27 : 15);
            e.result_value = clip32(s);
            e.result_index = 6'(j);
            e.last = (j == nf - 1);
            pending_scores.push_back(e);
         end
      end
      samples_done++;
      clear_sample();
   endfunction

   function automatic void apply_beat(req_type r);
      case (r.cmd)
         CMD_LOAD_MEAN: begin
            mean_shadow[r.col_index] = longint'(r.value);
            mean_loaded[r.col_index] = 1'b1;
         end
         CMD_LOAD_BASIS: begin
            basis_shadow[r.row_index*NumFeat + r.col_index] = longint'(r.value);
            basis_loaded[r.row_index*NumFeat + r.col_index] = 1'b1;
         end
         CMD_LOAD_FGAIN: begin
            fgain_shadow[r.row_index] = longint'({1'b0, r.value});
            fgain_loaded[r.row_index] = 1'b1;
         end
         CMD_LOAD_IGAIN: begin
            igain_shadow[r.row_index] = longint'({1'b0, r.value});
            igain_loaded[r.row_index] = 1'b1;
         end
         CMD_DATA: predict_scores(r);
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
      errors++;
   endtask

   // Sends one beat and waits until the engine takes it. The start line is left
   // high so that a following beat can go out without a gap.
   task automatic send_beat(logic [2:0] cmd, int row, int col, logic [15:0] val);
      req_type r;
      int gap;
      r.cmd = cmd;
      r.row_index = 4'(row);
      r.col_index = 6'(col);
      r.value = val;
      gap = (!steady && $urandom_range(99) < 7) ? 1 : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      apply_beat(r);
      beats_sent++;
   endtask

   task automatic write_reg(reg_index_type idx, int v);
      start <= 1'b0;
      @(posedge clock);
      while (pending_scores.size() != 0 || busy) @(posedge clock);
      repeat (DrainPause) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 7'(v);
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_INVERSE_MODE:  mode_inverse = v[0];
         REG_WHITEN_ENABLE: mode_whiten = v[0];
         REG_FEATURES:      feat_reg = v & 8'h7f;
         REG_COMPONENTS:    comp_reg = v & 8'h1f;
         default: ;
      endcase
      clear_sample();
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_mode(bit inv, bit wh, int feats, int comps);
      write_reg(REG_INVERSE_MODE, {6'($urandom_range(63)), inv});
      write_reg(REG_WHITEN_ENABLE, {6'($urandom_range(63)), wh});
      write_reg(REG_FEATURES, feats);
      write_reg(REG_COMPONENTS, comps);
      settings_used++;
   endtask

   function automatic logic [15:0] pick_word();
      case ($urandom_range(7))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'h1000;
         2: return 16'hffff;
         default: return 16'($urandom_range(0, 16384));
      endcase
   endfunction

   // Loads every table entry the current setting reads and that is still empty.
   task automatic fill_tables();
      int nf, nc;
      nf = feat_count();
      nc = comp_count();
      for (int j = 0; j < nf; j++)
         if (!mean_loaded[j]) send_beat(CMD_LOAD_MEAN, $urandom_range(15), j, pick_word());
      for (int k = 0; k < nc; k++) begin
         for (int j = 0; j < nf; j++)
            if (!basis_loaded[k*NumFeat + j]) send_beat(CMD_LOAD_BASIS, k, j, pick_word());
         if (mode_whiten && !mode_inverse && !fgain_loaded[k])
            send_beat(CMD_LOAD_FGAIN, k, $urandom_range(63), pick_gain());
         if (mode_whiten && mode_inverse && !igain_loaded[k])
            send_beat(CMD_LOAD_IGAIN, k, $urandom_range(63), pick_gain());
      end
   endtask

   task automatic send_sample(int beats);
      for (int i = 0; i < beats; i++)
         send_beat(CMD_DATA, $urandom_range(15), $urandom_range(63), pick_word());
   endtask

   function automatic int sample_len();
      return mode_inverse ? comp_count() : feat_count();
   endfunction

   // Worst-case arithmetic: largest differences against the most negative basis.
   task automatic test_forward_extremes();
      set_mode(1'b0, 1'b0, 3, 2);
      for (int j = 0; j < 3; j++) begin
         send_beat(CMD_LOAD_MEAN, 0, j, 16'h8000);
         for (int k = 0; k < 2; k++) send_beat(CMD_LOAD_BASIS, k, j, 16'h8000);
      end
      send_beat(CMD_DATA, 0, 0, 16'h7fff);
      send_beat(CMD_DATA, 15, 63, 16'h7fff);
      send_beat(CMD_DATA, 9, 33, 16'h7fff);
      for (int k = 0; k < 2; k++) send_beat(CMD_LOAD_FGAIN, k, 0, 16'hffff);
      write_reg(REG_WHITEN_ENABLE, 1);
      send_sample(3);
   endtask

   task automatic test_inverse(bit wh);
      set_mode(1'b1, wh, 4, 3);
      fill_tables();
      send_sample(sample_len());
      send_sample(sample_len());
   endtask

   task automatic test_size_limits();
      // Out-of-range writes clamp to the largest and smallest sizes.
      set_mode(1'b0, 1'b0, 100, 0);
      fill_tables();
      send_sample(sample_len());
      set_mode(1'b1, 1'b1, 0, 31);
      fill_tables();
      send_sample(sample_len());
      set_mode(1'b0, 1'b1, 1, 16);
      fill_tables();
      send_sample(sample_len());
   endtask

   task automatic test_unknown_and_abandon();
      set_mode(1'b0, 1'b0, 5, 2);
      fill_tables();
      send_beat(3'd5, 15, 63, 16'hffff);
      send_sample(3);
      send_beat(3'd7, 0, 0, 16'h0000);
      send_beat(3'd6, 10, 21, 16'h5555);
      // A register write drops the three elements already taken.
      write_reg(REG_FEATURES, 5);
      send_sample(sample_len());
      set_mode(1'b1, 1'b0, 5, 4);
      fill_tables();
      send_sample(2);
      write_reg(REG_COMPONENTS, 4);
      send_sample(sample_len());
   endtask

   task automatic test_random_traffic();
      int start_beats, nf, nc, phase, n;
      bit inv, wh;
      start_beats = beats_sent;
      phase = 0;
      while (beats_sent - start_beats < 80) begin
         steady = (phase == 0 || phase == 1);
         inv = $urandom_range(1);
         wh = $urandom_range(1);
         nf = ($urandom_range(5) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
         nc = ($urandom_range(5) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
         set_mode(inv, wh, nf, nc);
         fill_tables();
         repeat ($urandom_range(2, 5)) begin
            n = sample_len();
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(9) == 0) begin
                  case ($urandom_range(4))
                     0: send_beat(3'($urandom_range(5, 7)), $urandom_range(15),
                                  $urandom_range(63), 16'($urandom));
                     1: send_beat(CMD_LOAD_MEAN, $urandom_range(15), $urandom_range(63),
                                  pick_word());
                     2: send_beat(CMD_LOAD_BASIS, $urandom_range(15), $urandom_range(63),
                                  pick_word());
                     3: send_beat(CMD_LOAD_FGAIN, $urandom_range(15), $urandom_range(63),
                                  pick_gain());
                     default: send_beat(CMD_LOAD_IGAIN, $urandom_range(15),
                                        $urandom_range(63), pick_gain());
                  endcase
               end
               send_beat(CMD_DATA, $urandom_range(15), $urandom_range(63), pick_word());
            end
         end
         phase++;
      end
      steady = 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         scores_seen++;
         if (pending_scores.size() == 0) begin
            report_mismatch("unexpected result, index", rsp_data.result_index, -1);
         end else begin
            e = pending_scores.pop_front();
            if (rsp_data.result_value !== e.result_value)
               report_mismatch("result_value", rsp_data.result_value, e.result_value);
            if (rsp_data.result_index !== e.result_index)
               report_mismatch("result_index", rsp_data.result_index, e.result_index);
            if (rsp_data.last !== e.last)
               report_mismatch("last", rsp_data.last, e.last);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
         $display("timeout after %0d idle cycles", quiet_cycles);
         $display("FAIL pca_projection_engine");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_index <= REG_INVERSE_MODE;
      csr_wdata <= '0;
      mode_inverse = 1'b0;
      mode_whiten = 1'b0;
      feat_reg = 64;
      comp_reg = 16;
      clear_sample();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_forward_extremes();
      test_inverse(1'b0);
      test_inverse(1'b1);
      test_size_limits();
      test_unknown_and_abandon();
      test_random_traffic();
      start <= 1'b0;
      @(posedge clock);
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (DrainPause) @(posedge clock);
      $display("covered %0d beats, %0d samples, %0d results over %0d register settings",
               beats_sent, samples_done, scores_seen, settings_used);
      $display("forward and inverse, whitened and plain, sizes 1 to 64 by 1 to 16");
      if (errors == 0) begin
         $display("PASS pca_projection_engine");
      end else begin
         $display("%0d mismatches", errors);
         $display("FAIL pca_projection_engine");
      end
      $finish;
   end

endmodule
